FILE: hdl/c2d3_pkg.sv
package c2d3_pkg;

  // Sizes of the stream and of the register file
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int PIX_W         = 8;
  localparam int TAP_W         = 8;
  localparam int TAP_COUNT     = 9;
  localparam int BIAS_W        = 19;
  localparam int OUT_W         = 21;
  localparam int PROD_W        = 17;
  localparam int RSUM_W        = 19;
  localparam int IMG_W_W       = 11;
  localparam int IMG_H_W       = 13;
  localparam int ROW_W         = 12;
  localparam int ADDR_W        = 6;
  localparam int DATA_W        = 64;
  localparam int REG_IDX_W     = 3;

  // Register indexes (byte address 8*index)
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TAPS_FIRST   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TAP_LAST     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BIAS         = 3'd4;

  // Register reset values
  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd1024;

  // 3x3 window, entry r*3+c, row 0 topmost, column 0 oldest
  typedef logic [TAP_COUNT-1:0][PIX_W-1:0] win_t;
  // Nine taps, tap k multiplies window entry k
  typedef logic [TAP_COUNT-1:0][TAP_W-1:0] taps_t;

  // Position marks that travel with a result word
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } mark_t;

endpackage

FILE: hdl/c2d3_lbuf.sv
// Two line stores: upper holds row r-2, middle holds row r-1.
// Read data is registered; the read address runs one pixel ahead.
module c2d3_lbuf #(
  parameter int MAX_WIDTH = c2d3_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic [c2d3_pkg::PIX_W-1:0]   px_in,
  output logic [c2d3_pkg::PIX_W-1:0]   upper_q,
  output logic [c2d3_pkg::PIX_W-1:0]   middle_q
);

  logic [c2d3_pkg::PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [c2d3_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];

  // Shift the column up one row on each accepted pixel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= middle_q;
      middle_mem[wr_addr] <= px_in;
    end
  end

  // Registered reads; write and read addresses differ on an accepted pixel unless a geometry write restarts the frame
  always_ff @(posedge clk) begin
    upper_q  <= upper_mem[rd_addr];
    middle_q <= middle_mem[rd_addr];
  end

endmodule

FILE: hdl/c2d3_mac.sv
// Multiply-accumulate pipe: nine products summed per window row,
// then the three row sums plus bias into the output register.
module c2d3_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  c2d3_pkg::win_t                   win,
  input  c2d3_pkg::mark_t                  in_mark,
  input  c2d3_pkg::taps_t                  taps,
  input  logic [c2d3_pkg::BIAS_W-1:0]      bias,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [c2d3_pkg::OUT_W-1:0] filtered,
  output c2d3_pkg::mark_t                  out_mark
);

  logic                                  s2_valid;
  logic signed [c2d3_pkg::RSUM_W-1:0]    row_sum [3];
  logic signed [c2d3_pkg::RSUM_W-1:0]    row_sum_next [3];
  c2d3_pkg::mark_t                       s2_mark;
  logic                                  out_free;
  logic signed [c2d3_pkg::OUT_W-1:0]     filtered_next;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !s2_valid || out_free;

  // Products of signed tap and unsigned pixel, summed per row
  always_comb begin
    logic signed [c2d3_pkg::PROD_W-1:0] prod [c2d3_pkg::TAP_COUNT];
    for (int k = 0; k < c2d3_pkg::TAP_COUNT; k++) begin
      prod[k] = $signed({{(c2d3_pkg::PROD_W - c2d3_pkg::TAP_W){taps[k][c2d3_pkg::TAP_W-1]}},
                         taps[k]})
              * $signed({{(c2d3_pkg::PROD_W - c2d3_pkg::PIX_W){1'b0}}, win[k]});
    end
    for (int r = 0; r < 3; r++) begin
      row_sum_next[r] = c2d3_pkg::RSUM_W'(prod[3*r])
                      + c2d3_pkg::RSUM_W'(prod[3*r+1])
                      + c2d3_pkg::RSUM_W'(prod[3*r+2]);
    end
  end

  // Row sums and bias; the exact result always fits in 21 bits
  assign filtered_next = c2d3_pkg::OUT_W'(row_sum[0])
                       + c2d3_pkg::OUT_W'(row_sum[1])
                       + c2d3_pkg::OUT_W'(row_sum[2])
                       + c2d3_pkg::OUT_W'($signed(bias));

  // Row-sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_ready) begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int r = 0; r < 3; r++) begin
        row_sum[r] <= row_sum_next[r];
      end
      s2_mark <= in_mark;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      filtered <= filtered_next;
      out_mark <= s2_mark;
    end
  end

endmodule

FILE: hdl/conv2d_3x3_stream.sv
// Streaming 3x3 valid-region correlation over a raster pixel stream.
// Throughput: one pixel word per cycle; ready drops only under output backpressure.
// A result word reaches the output through three register stages after the pixel that
// completes its window: window, row sums of the products, output word.
// Reset (rst, synchronous): counters, window and pipe valids clear, registers take defaults.
// Line stores are not cleared; border positions never read unwritten entries.
module conv2d_3x3_stream #(
  parameter int MAX_WIDTH = c2d3_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [c2d3_pkg::PIX_W-1:0]         pixel,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [c2d3_pkg::OUT_W-1:0]  filtered,
  output logic                               row_end,
  output logic                               frame_end,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [c2d3_pkg::ADDR_W-1:0]        paddr,
  input  logic [c2d3_pkg::DATA_W-1:0]        pwdata,
  output logic [c2d3_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WE = (CW + 1 > c2d3_pkg::IMG_W_W) ? CW + 1 : c2d3_pkg::IMG_W_W;

  // Configuration registers
  logic [c2d3_pkg::IMG_W_W-1:0]  image_width;
  logic [c2d3_pkg::IMG_H_W-1:0]  image_height;
  logic [c2d3_pkg::DATA_W-1:0]   taps_first_eight;
  logic [c2d3_pkg::TAP_W-1:0]    tap_last;
  logic [c2d3_pkg::BIAS_W-1:0]   bias;

  logic                          cfg_wr;
  logic [c2d3_pkg::REG_IDX_W-1:0] cfg_idx;
  logic                          geom_wr;

  // Geometry in use
  logic [WE-1:0]                 w_raw;
  logic [WE-1:0]                 w_use;
  logic [c2d3_pkg::IMG_H_W-1:0]  h_use;
  logic [CW-1:0]                 last_col;
  logic [c2d3_pkg::ROW_W-1:0]    last_row;

  // Position and window
  logic [CW-1:0]                 col;
  logic [CW-1:0]                 col_next;
  logic [c2d3_pkg::ROW_W-1:0]    row;
  logic [c2d3_pkg::ROW_W-1:0]    row_next;
  logic                          accept;
  logic                          at_last_col;
  logic                          produce;
  c2d3_pkg::win_t                win;
  logic                          win_valid;
  c2d3_pkg::mark_t               win_mark;
  logic                          mac_ready;
  c2d3_pkg::mark_t               res_mark;
  logic [c2d3_pkg::PIX_W-1:0]    upper_q;
  logic [c2d3_pkg::PIX_W-1:0]    middle_q;

  // APB decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[c2d3_pkg::ADDR_W-1:c2d3_pkg::ADDR_W-c2d3_pkg::REG_IDX_W];
  assign geom_wr = cfg_wr && (cfg_idx == c2d3_pkg::REG_IMAGE_WIDTH ||
                              cfg_idx == c2d3_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= c2d3_pkg::IMAGE_WIDTH_RST;
      image_height     <= c2d3_pkg::IMAGE_HEIGHT_RST;
      taps_first_eight <= '0;
      tap_last         <= '0;
      bias             <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        c2d3_pkg::REG_IMAGE_WIDTH:  image_width      <= pwdata[c2d3_pkg::IMG_W_W-1:0];
        c2d3_pkg::REG_IMAGE_HEIGHT: image_height     <= pwdata[c2d3_pkg::IMG_H_W-1:0];
        c2d3_pkg::REG_TAPS_FIRST:   taps_first_eight <= pwdata;
        c2d3_pkg::REG_TAP_LAST:     tap_last         <= pwdata[c2d3_pkg::TAP_W-1:0];
        c2d3_pkg::REG_BIAS:         bias             <= pwdata[c2d3_pkg::BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      c2d3_pkg::REG_IMAGE_WIDTH:  prdata = c2d3_pkg::DATA_W'(image_width);
      c2d3_pkg::REG_IMAGE_HEIGHT: prdata = c2d3_pkg::DATA_W'(image_height);
      c2d3_pkg::REG_TAPS_FIRST:   prdata = taps_first_eight;
      c2d3_pkg::REG_TAP_LAST:     prdata = c2d3_pkg::DATA_W'(tap_last);
      c2d3_pkg::REG_BIAS:         prdata = c2d3_pkg::DATA_W'(bias);
      default:                    prdata = '0;
    endcase
  end

  // Clamp width to 3..MAX_WIDTH and height to 3..4096
  assign w_raw = WE'(image_width);
  always_comb begin
    if (w_raw < WE'(3)) begin
      w_use = WE'(3);
    end else if (w_raw > WE'(MAX_WIDTH)) begin
      w_use = WE'(MAX_WIDTH);
    end else begin
      w_use = w_raw;
    end
    if (image_height < c2d3_pkg::IMG_H_W'(3)) begin
      h_use = c2d3_pkg::IMG_H_W'(3);
    end else if (image_height > c2d3_pkg::IMG_H_W'(c2d3_pkg::MAX_HEIGHT)) begin
      h_use = c2d3_pkg::IMG_H_W'(c2d3_pkg::MAX_HEIGHT);
    end else begin
      h_use = image_height;
    end
  end
  assign last_col = CW'(w_use - WE'(1));
  assign last_row = c2d3_pkg::ROW_W'(h_use - c2d3_pkg::IMG_H_W'(1));

  // Window stage holds a pending result until the MAC pipe takes it
  assign in_ready    = !win_valid || mac_ready;
  assign accept      = in_valid && in_ready;
  assign at_last_col = (col == last_col);
  assign produce     = (row >= c2d3_pkg::ROW_W'(2)) && (col >= CW'(2));

  // Raster position; geometry writes restart the frame
  always_comb begin
    col_next = col;
    row_next = row;
    if (geom_wr) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_next = '0;
        row_next = (row == last_row) ? '0 : row + c2d3_pkg::ROW_W'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Shift the window left, new column from line stores and pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '0;
      win_valid <= 1'b0;
      win_mark  <= '0;
    end else if (accept) begin
      for (int r = 0; r < 3; r++) begin
        win[3*r]   <= win[3*r+1];
        win[3*r+1] <= win[3*r+2];
      end
      win[2]             <= upper_q;
      win[5]             <= middle_q;
      win[8]             <= pixel;
      win_valid          <= produce;
      win_mark.row_end   <= at_last_col;
      win_mark.frame_end <= at_last_col && (row == last_row);
    end else if (mac_ready) begin
      win_valid <= 1'b0;
    end
  end

  c2d3_lbuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lbuf (
    .clk      (clk),
    .wr_en    (accept),
    .wr_addr  (col),
    .rd_addr  (col_next),
    .px_in    (pixel),
    .upper_q  (upper_q),
    .middle_q (middle_q)
  );

  c2d3_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win_valid),
    .in_ready  (mac_ready),
    .win       (win),
    .in_mark   (win_mark),
    .taps      ({tap_last, taps_first_eight}),
    .bias      (bias),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered),
    .out_mark  (res_mark)
  );

  assign row_end   = res_mark.row_end;
  assign frame_end = res_mark.frame_end;

endmodule

FILE: test/testbench.sv
module testbench;

  // Address 56 decodes to no register; writes there must be dropped
  localparam logic [c2d3_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int RANDOM_PIXELS = 700;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 400;

  typedef enum int {MODE_TX14_RX50, MODE_TX50_RX14, MODE_NO_IDLE} idle_mode_t;

  // One result word as the block should present it
  typedef struct {
    logic signed [c2d3_pkg::OUT_W-1:0] filtered;
    c2d3_pkg::mark_t                   marks;
  } conv_word_t;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               in_valid  = 1'b0;
  logic                               in_ready;
  logic [c2d3_pkg::PIX_W-1:0]         pixel     = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [c2d3_pkg::OUT_W-1:0]  filtered;
  logic                               row_end;
  logic                               frame_end;
  logic                               psel      = 1'b0;
  logic                               penable   = 1'b0;
  logic                               pwrite    = 1'b0;
  logic [c2d3_pkg::ADDR_W-1:0]        paddr     = '0;
  logic [c2d3_pkg::DATA_W-1:0]        pwdata    = '0;
  logic [c2d3_pkg::DATA_W-1:0]        prdata;
  logic                               pready;

  logic [c2d3_pkg::PIX_W-1:0] pending_pixels[$];
  conv_word_t                 predicted_words[$];
  int                         error_count = 0;
  idle_mode_t                 idle_mode   = MODE_NO_IDLE;

  // Long receiver hold, requested by the stimulus and timed by its own counter
  int rx_hold_req  = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;

  // Shadow of the block: geometry in use, kernel, line stores, window, position
  int                           use_width  = c2d3_pkg::MAX_WIDTH_DEF;
  int                           use_height = int'(c2d3_pkg::IMAGE_HEIGHT_RST);
  logic [c2d3_pkg::DATA_W-1:0]  cur_taps   = '0;
  logic [c2d3_pkg::TAP_W-1:0]   cur_tap8   = '0;
  logic [c2d3_pkg::BIAS_W-1:0]  cur_bias   = '0;
  logic [c2d3_pkg::PIX_W-1:0]   upper_line [c2d3_pkg::MAX_WIDTH_DEF];
  logic [c2d3_pkg::PIX_W-1:0]   middle_line[c2d3_pkg::MAX_WIDTH_DEF];
  c2d3_pkg::win_t               pix_window = '0;
  int                           col_pos    = 0;
  int                           row_pos    = 0;

  conv2d_3x3_stream dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered),
    .row_end   (row_end),
    .frame_end (frame_end),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the shadow by one pixel and queue the word it completes, if any
  task automatic convolve_pixel(input logic [c2d3_pkg::PIX_W-1:0] px);
    int         acc;
    int         tap;
    conv_word_t word;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 2; c++) begin
        pix_window[r*3+c] = pix_window[r*3+c+1];
      end
    end
    pix_window[2] = upper_line[col_pos];
    pix_window[5] = middle_line[col_pos];
    pix_window[8] = px;
    upper_line[col_pos]  = middle_line[col_pos];
    middle_line[col_pos] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      acc = int'($signed(cur_bias));
      for (int k = 0; k < c2d3_pkg::TAP_COUNT; k++) begin
        if (k == c2d3_pkg::TAP_COUNT - 1) begin
          tap = int'($signed(cur_tap8));
        end else begin
          tap = int'($signed(cur_taps[c2d3_pkg::TAP_W*k +: c2d3_pkg::TAP_W]));
        end
        acc += tap * int'(pix_window[k]);
      end
      word.filtered        = acc[c2d3_pkg::OUT_W-1:0];
      word.marks.row_end   = (col_pos == use_width - 1);
      word.marks.frame_end = word.marks.row_end && (row_pos == use_height - 1);
      predicted_words.push_back(word);
    end
    col_pos++;
    if (col_pos >= use_width) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= use_height) row_pos = 0;
    end
  endtask

  // Setup and access phase; the shadow takes the value at the access edge
  task automatic write_reg(input logic [c2d3_pkg::REG_IDX_W-1:0] idx,
                           input logic [c2d3_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      c2d3_pkg::REG_IMAGE_WIDTH: begin
        use_width = int'(value[c2d3_pkg::IMG_W_W-1:0]);
        if (use_width < 3) use_width = 3;
        if (use_width > c2d3_pkg::MAX_WIDTH_DEF) use_width = c2d3_pkg::MAX_WIDTH_DEF;
        col_pos = 0;
        row_pos = 0;
      end
      c2d3_pkg::REG_IMAGE_HEIGHT: begin
        use_height = int'(value[c2d3_pkg::IMG_H_W-1:0]);
        if (use_height < 3) use_height = 3;
        if (use_height > c2d3_pkg::MAX_HEIGHT) use_height = c2d3_pkg::MAX_HEIGHT;
        col_pos = 0;
        row_pos = 0;
      end
      c2d3_pkg::REG_TAPS_FIRST: cur_taps = value;
      c2d3_pkg::REG_TAP_LAST:   cur_tap8 = value[c2d3_pkg::TAP_W-1:0];
      c2d3_pkg::REG_BIAS:       cur_bias = value[c2d3_pkg::BIAS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Kernel and bias, with the first eight taps all-min or all-max now and then
  task automatic write_random_kernel();
    case ($urandom_range(0, 5))
      0:       write_reg(c2d3_pkg::REG_TAPS_FIRST, {8{8'h80}});
      1:       write_reg(c2d3_pkg::REG_TAPS_FIRST, {8{8'h7F}});
      default: write_reg(c2d3_pkg::REG_TAPS_FIRST, {$urandom, $urandom});
    endcase
    write_reg(c2d3_pkg::REG_TAP_LAST, {$urandom, 24'($urandom), 8'($urandom)});
    case ($urandom_range(0, 4))
      0:       write_reg(c2d3_pkg::REG_BIAS, {$urandom, 13'($urandom), 19'h3FFFF});
      1:       write_reg(c2d3_pkg::REG_BIAS, {$urandom, 13'($urandom), 19'h40000});
      default: write_reg(c2d3_pkg::REG_BIAS, {$urandom, 13'($urandom), 19'($urandom)});
    endcase
  endtask

  task automatic push_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_pixels.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
      end else begin
        pending_pixels.push_back(c2d3_pkg::PIX_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Block is idle once every pixel is in, every word is out and the pipe is flushed
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid || predicted_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    error_count++;
  endtask

  // Pixel driver
  always @(posedge clk) begin : pixel_driver
    bit gap;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) convolve_pixel(pixel);
      if (!in_valid || in_ready) begin
        gap = (idle_mode == MODE_TX14_RX50) ? ($urandom_range(0, 99) < 14) :
              (idle_mode == MODE_TX50_RX14) ? ($urandom_range(0, 99) < 50) : 1'b0;
        if (pending_pixels.size() != 0 && !gap) begin
          in_valid <= 1'b1;
          pixel    <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold timer
  always @(posedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Result monitor: each accepted word against the oldest prediction
  always @(posedge clk) begin : result_monitor
    conv_word_t want;
    bit         stall;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_words.size() == 0) begin
          report("unexpected word, filtered", 0, int'(filtered));
        end else begin
          want = predicted_words.pop_front();
          if (filtered !== want.filtered) report("filtered", want.filtered, filtered);
          if (row_end !== want.marks.row_end) report("row_end", want.marks.row_end, row_end);
          if (frame_end !== want.marks.frame_end) begin
            report("frame_end", want.marks.frame_end, frame_end);
          end
        end
      end
      stall = (idle_mode == MODE_TX14_RX50) ? ($urandom_range(0, 99) < 50) :
              (idle_mode == MODE_TX50_RX14) ? ($urandom_range(0, 99) < 14) : 1'b0;
      out_ready <= (rx_hold_left == 0) && !stall;
    end
  end

  initial begin : stimulus
    int                           sent;
    int                           n;
    logic [c2d3_pkg::IMG_W_W-1:0] w_reg;
    logic [c2d3_pkg::IMG_H_W-1:0] h_reg;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Largest positive sum: 3x3 frame (height below range), max taps, max bias, white
    write_reg(c2d3_pkg::REG_IMAGE_WIDTH, 64'd3);
    write_reg(c2d3_pkg::REG_IMAGE_HEIGHT, 64'd1);
    write_reg(c2d3_pkg::REG_TAPS_FIRST, {8{8'h7F}});
    write_reg(c2d3_pkg::REG_TAP_LAST, 64'h7F);
    write_reg(c2d3_pkg::REG_BIAS, 64'h3FFFF);
    repeat (9) pending_pixels.push_back(8'hFF);
    wait_drained();

    // Unmapped address, then most negative sum after a mid-frame geometry change
    write_reg(REG_UNMAPPED, '1);
    write_reg(c2d3_pkg::REG_TAPS_FIRST, {8{8'h80}});
    write_reg(c2d3_pkg::REG_TAP_LAST, 64'h80);
    write_reg(c2d3_pkg::REG_BIAS, 64'h40000);
    repeat (4) pending_pixels.push_back(8'hFF);
    wait_drained();
    write_reg(c2d3_pkg::REG_IMAGE_WIDTH, 64'd2);
    repeat (9) pending_pixels.push_back(8'hFF);
    wait_drained();

    // Backpressure: long output hold while pixels keep coming, then a sender pause
    write_reg(c2d3_pkg::REG_IMAGE_WIDTH, 64'd5);
    write_reg(c2d3_pkg::REG_IMAGE_HEIGHT, 64'd6);
    write_random_kernel();
    push_random_pixels(60);
    rx_hold_req <= rx_hold_req + 1;
    wait_drained();
    push_random_pixels(30);
    wait_drained();

    // Random phases over the three idling patterns
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      idle_mode = (sent < RANDOM_PIXELS / 3)     ? MODE_TX14_RX50 :
                  (sent < 2 * RANDOM_PIXELS / 3) ? MODE_TX50_RX14 : MODE_NO_IDLE;
      if (sent == 0 || $urandom_range(0, 3) != 0) begin
        w_reg = c2d3_pkg::IMG_W_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
                                                                  $urandom_range(3, 9));
        h_reg = c2d3_pkg::IMG_H_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
                                                                  $urandom_range(3, 7));
        write_reg(c2d3_pkg::REG_IMAGE_WIDTH, {$urandom, 21'($urandom), w_reg});
        write_reg(c2d3_pkg::REG_IMAGE_HEIGHT, {$urandom, 19'($urandom), h_reg});
      end
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNMAPPED, {$urandom, $urandom});
      write_random_kernel();
      n = $urandom_range(0, 2) * use_width * use_height
          + $urandom_range(1, use_width * use_height);
      push_random_pixels(n);
      sent += n;
      wait_drained();
    end

    // Widest rows (width above range): part of the first row, no word may appear
    idle_mode = MODE_NO_IDLE;
    write_reg(c2d3_pkg::REG_IMAGE_WIDTH, 64'd2047);
    write_reg(c2d3_pkg::REG_IMAGE_HEIGHT, 64'd3);
    write_random_kernel();
    push_random_pixels(40);
    wait_drained();

    // Tallest frame (height above range), narrowest rows: no frame end early on
    write_reg(c2d3_pkg::REG_IMAGE_WIDTH, 64'd3);
    write_reg(c2d3_pkg::REG_IMAGE_HEIGHT, 64'd8191);
    write_random_kernel();
    push_random_pixels(60);
    wait_drained();

    if (error_count == 0 && predicted_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
